[rtl/ppmcs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppmcs_pkg
// Shared types and constants of the preemptive priority multi-cpu scheduler.
// ----------------------------------------------------------------------------
package ppmcs_pkg;

  localparam int MAX_JOBS = 64;
  localparam int MAX_CPUS = 4;
  localparam int IDX_W    = $clog2(MAX_JOBS);
  localparam int CNT_W    = $clog2(MAX_JOBS + 1);
  localparam int CPU_W    = 2;
  localparam int NCPU_W   = 3;
  localparam int TIME_W   = 16;
  localparam int PRI_W    = 8;

  localparam logic [CNT_W-1:0]  JOBS_FULL = CNT_W'(MAX_JOBS);
  localparam logic [NCPU_W-1:0] CPUS_MAX  = NCPU_W'(MAX_CPUS);
  localparam logic [TIME_W-1:0] TIME_MAX  = '1;

  // input kinds carried in tuser
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_EMIT,
    ST_WAIT
  } state_e;

  // one entry of the running top list
  typedef struct packed {
    logic              vld;
    logic [IDX_W-1:0]  idx;
    logic [PRI_W-1:0]  pri;
    logic [TIME_W-1:0] arr;
    logic [TIME_W-1:0] rem;
  } slot_t;

  // controller to datapath
  typedef struct packed {
    logic in_ready;
    logic scan_en;
    logic upd_en;
    logic emit_en;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_hs;
    logic in_mode;
    logic scan_busy;
    logic upd_last;
    logic out_hs;
    logic out_last;
  } status_t;

endpackage

[rtl/ppmcs_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppmcs_ctrl
// Sequencer: load or tick, table scan, remaining-time update, result output.
// ----------------------------------------------------------------------------
module ppmcs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ppmcs_pkg::status_t status_i,
  output ppmcs_pkg::cmd_t    cmd_o
);
  import ppmcs_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (status_i.in_hs) begin
          state_d = (status_i.in_mode == MODE_TICK) ? ST_SCAN : ST_WAIT;
        end
      end
      ST_SCAN: begin
        if (!status_i.scan_busy) state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (status_i.upd_last) state_d = ST_EMIT;
      end
      ST_EMIT: state_d = ST_WAIT;
      ST_WAIT: begin
        if (status_i.out_hs) state_d = status_i.out_last ? ST_IDLE : ST_EMIT;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE:   cmd_o.in_ready = 1'b1;
      ST_SCAN:   cmd_o.scan_en  = 1'b1;
      ST_UPDATE: cmd_o.upd_en   = 1'b1;
      ST_EMIT:   cmd_o.emit_en  = 1'b1;
      ST_WAIT:   cmd_o = '0;
      default:   cmd_o = '0;
    endcase
  end

endmodule

[rtl/ppmcs_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppmcs_dp
// Job tables, top-list insertion during the scan, counters and output register.
// ----------------------------------------------------------------------------
module ppmcs_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ppmcs_pkg::cmd_t    cmd_i,
  output ppmcs_pkg::status_t status_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_data_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [39:0]        s_axis_tdata,
  input  logic [0:0]         s_axis_tuser,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [31:0]        m_axis_tdata,
  output logic               m_axis_tlast
);
  import ppmcs_pkg::*;

  // job tables
  logic [TIME_W-1:0] arr_mem [MAX_JOBS];
  logic [TIME_W-1:0] rem_mem [MAX_JOBS];
  logic [PRI_W-1:0]  pri_mem [MAX_JOBS];

  logic [NCPU_W-1:0] cfg_q;
  logic [CNT_W-1:0]  loaded_q, unfin_q, scan_q;
  logic [TIME_W-1:0] time_q;
  logic [CPU_W-1:0]  cpu_q;
  logic              tick_q;
  logic              rd_vld_q;
  logic [IDX_W-1:0]  rd_idx_q;
  logic [TIME_W-1:0] rd_arr_q, rd_rem_q;
  logic [PRI_W-1:0]  rd_pri_q;
  slot_t             top_q [MAX_CPUS];
  slot_t             cand;
  logic [MAX_CPUS-1:0] ahead;

  logic              out_vld_q, out_last_q;
  logic [31:0]       out_data_q;

  logic [TIME_W-1:0] in_arr, in_dur;
  logic [PRI_W-1:0]  in_pri;
  logic              in_hs, out_hs, full, load_ok, scan_more;
  logic [NCPU_W-1:0] ncpu;
  logic [CPU_W-1:0]  cpu_last;
  slot_t             cur;
  logic              cur_fin;

  assign in_arr = s_axis_tdata[15:0];
  assign in_dur = s_axis_tdata[31:16];
  assign in_pri = s_axis_tdata[39:32];

  assign s_axis_tready = cmd_i.in_ready;
  assign in_hs     = s_axis_tvalid && s_axis_tready;
  assign out_hs    = out_vld_q && m_axis_tready;
  assign full      = (loaded_q == JOBS_FULL);
  assign load_ok   = in_hs && (s_axis_tuser[0] == MODE_LOAD) && !full;
  assign scan_more = (scan_q < loaded_q);

  // effective cpu count, clamped to 1..MAX_CPUS
  always_comb begin
    priority if (cfg_q == '0) ncpu = NCPU_W'(1);
    else if (cfg_q > CPUS_MAX) ncpu = CPUS_MAX;
    else ncpu = cfg_q;
  end
  assign cpu_last = CPU_W'(ncpu - NCPU_W'(1));
  assign cur      = top_q[cpu_q];
  assign cur_fin  = cur.vld && (cur.rem == TIME_W'(1));

  assign status_o.in_hs     = in_hs;
  assign status_o.in_mode   = s_axis_tuser[0];
  assign status_o.scan_busy = scan_more || rd_vld_q;
  assign status_o.upd_last  = (cpu_q == cpu_last);
  assign status_o.out_hs    = out_hs;
  assign status_o.out_last  = out_last_q;

  // configuration register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CPUS_MAX;
    end else if (cfg_valid_i) begin
      cfg_q <= cfg_data_i[NCPU_W-1:0];
    end
  end

  // table writes and the scan read port
  always_ff @(posedge clk_i) begin
    if (load_ok) begin
      arr_mem[loaded_q[IDX_W-1:0]] <= in_arr;
      rem_mem[loaded_q[IDX_W-1:0]] <= in_dur;
      pri_mem[loaded_q[IDX_W-1:0]] <= in_pri;
    end else if (cmd_i.upd_en && cur.vld) begin
      rem_mem[cur.idx] <= cur.rem - TIME_W'(1);
    end
    rd_arr_q <= arr_mem[scan_q[IDX_W-1:0]];
    rd_rem_q <= rem_mem[scan_q[IDX_W-1:0]];
    rd_pri_q <= pri_mem[scan_q[IDX_W-1:0]];
    rd_idx_q <= scan_q[IDX_W-1:0];
  end

  // candidate from the read stage and its place in the sorted list
  always_comb begin
    cand.vld = rd_vld_q && (rd_rem_q != '0) && (rd_arr_q <= time_q);
    cand.idx = rd_idx_q;
    cand.pri = rd_pri_q;
    cand.arr = rd_arr_q;
    cand.rem = rd_rem_q;
    for (int k = 0; k < MAX_CPUS; k++) begin
      ahead[k] = !top_q[k].vld || (cand.pri > top_q[k].pri) ||
                 ((cand.pri == top_q[k].pri) && (cand.arr < top_q[k].arr));
    end
  end

  // control registers, scan and top list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= '0;
      unfin_q  <= '0;
      scan_q   <= '0;
      time_q   <= '0;
      cpu_q    <= '0;
      tick_q   <= 1'b0;
      rd_vld_q <= 1'b0;
      for (int k = 0; k < MAX_CPUS; k++) top_q[k] <= '0;
    end else begin
      rd_vld_q <= cmd_i.scan_en && scan_more;
      if (in_hs) begin
        tick_q <= (s_axis_tuser[0] == MODE_TICK);
        scan_q <= '0;
        cpu_q  <= '0;
        for (int k = 0; k < MAX_CPUS; k++) top_q[k] <= '0;
      end
      if (load_ok) begin
        loaded_q <= loaded_q + CNT_W'(1);
        if (in_dur != '0) unfin_q <= unfin_q + CNT_W'(1);
      end
      if (cmd_i.scan_en && scan_more) scan_q <= scan_q + CNT_W'(1);
      if (cand.vld) begin
        if (ahead[0]) top_q[0] <= cand;
        for (int k = 1; k < MAX_CPUS; k++) begin
          if (ahead[k]) top_q[k] <= ahead[k-1] ? top_q[k-1] : cand;
        end
      end
      if (cmd_i.upd_en) begin
        if (cur_fin) unfin_q <= unfin_q - CNT_W'(1);
        cpu_q <= status_o.upd_last ? '0 : cpu_q + CPU_W'(1);
      end
      if (out_hs) begin
        if (!out_last_q) begin
          cpu_q <= cpu_q + CPU_W'(1);
        end else if (tick_q && (unfin_q != '0) && (time_q != TIME_MAX)) begin
          time_q <= time_q + TIME_W'(1);
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (in_hs && (s_axis_tuser[0] == MODE_LOAD)) begin
      out_vld_q <= 1'b1;
    end else if (cmd_i.emit_en) begin
      out_vld_q <= 1'b1;
    end else if (out_hs) begin
      out_vld_q <= 1'b0;
    end
  end

  // top-list rem still holds the value before the update, so one means finished
  always_ff @(posedge clk_i) begin
    if (in_hs && (s_axis_tuser[0] == MODE_LOAD)) begin
      out_last_q <= 1'b1;
      out_data_q <= {4'b0, full,
                     (unfin_q == '0) && !(load_ok && (in_dur != '0)),
                     time_q, 1'b0,
                     full ? IDX_W'(0) : loaded_q[IDX_W-1:0],
                     1'b0, CPU_W'(0)};
    end else if (cmd_i.emit_en) begin
      out_last_q <= (cpu_q == cpu_last);
      out_data_q <= {4'b0, 1'b0, (unfin_q == '0), time_q,
                     cur_fin,
                     cur.vld ? cur.idx : IDX_W'(0),
                     cur.vld, cpu_q};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // unfinished jobs never outnumber loaded ones
  a_unfin_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unfin_q <= loaded_q) else $error("unfinished count exceeds loaded count");

  // scan pointer stays within the loaded part of the table
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_q <= loaded_q) else $error("scan pointer beyond table");

  // no new transaction is taken while a result is pending
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !s_axis_tready) else $error("input taken with result pending");

  // time only moves on the closing result of a tick
  a_time_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (time_q != $past(time_q)) |-> $past(out_hs && out_last_q && tick_q))
    else $error("time advanced outside tick end");

endmodule

[rtl/preemptive_priority_multi_cpu_scheduler_top.sv]
`timescale 1ns / 1ps
// A load's result is registered and offered in the cycle after acceptance.
// A tick scans the job table one entry per cycle (single read port of the
// job tables), then updates remaining times and gives one result per cpu.
// One input transaction is worked on at a time.
// Reset clears the job count, time and control; the tables need no clearing.
// ----------------------------------------------------------------------------
// preemptive_priority_multi_cpu_scheduler_top
// Priority scheduler of a job table over several cpus, one tick at a time.
// ----------------------------------------------------------------------------
module preemptive_priority_multi_cpu_scheduler_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,    // [2:0] active_cpus
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // job_arrival, job_duration, job_priority
  input  logic [0:0]  s_axis_tuser,  // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // cpu_index, job_valid, job_index,
                                     // job_finished, tick_time, all_done,
                                     // load_rejected
  output logic        m_axis_tlast
);
  import ppmcs_pkg::*;

  cmd_t    cmd;
  status_t status;

  ppmcs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  ppmcs_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

[tb/preemptive_priority_multi_cpu_scheduler_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preemptive_priority_multi_cpu_scheduler_top_tb
// Self-checking bench for the multi-cpu priority scheduler. A directed table
// covers the empty table, ties and zero-length jobs. Random phases follow,
// each with its own cpu count, mixing job loads with ticks. A final phase
// fills the table past full with extreme jobs. Every result transaction is
// checked field by field against a local scheduling model. The sender works
// in bursts and the receiver stalls at random, including one long hold-off.
// ----------------------------------------------------------------------------
module preemptive_priority_multi_cpu_scheduler_top_tb;
  import ppmcs_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD      = 400;
  localparam int SETTLE         = 100;

  typedef struct {
    logic [1:0]  cpu;
    logic        vld;
    logic [5:0]  idx;
    logic        fin;
    logic [15:0] t;
    logic        done;
    logic        rej;
    logic        last;
  } sched_res_t;

  typedef struct {
    logic        mode;
    logic [15:0] arr;
    logic [15:0] dur;
    logic [7:0]  pri;
    bit          typed;
    logic [5:0]  t_idx;
    logic        t_done;
    logic        t_rej;
  } job_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;  // job_arrival, job_duration, job_priority
  logic [0:0]  s_axis_tuser;  // mode
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;  // cpu_index, job_valid, job_index, job_finished,
                              // tick_time, all_done, load_rejected
  logic        m_axis_tlast;

  // scheduler image kept by the bench
  logic [15:0] job_arr [MAX_JOBS];
  logic [15:0] job_rem [MAX_JOBS];
  logic [7:0]  job_pri [MAX_JOBS];
  int          jobs_loaded;
  logic [15:0] sched_now;
  logic [2:0]  cpus_reg;

  sched_res_t  pending_res[$];
  int          errors;
  int          n_loads, n_ticks, n_rejects, n_checked;
  int          stall_pct, gap_pct;
  bit          hold_req;
  int          burst_left;

  preemptive_priority_multi_cpu_scheduler_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic bit any_pending_work();
    for (int i = 0; i < jobs_loaded; i++)
      if (job_rem[i] != 0) return 1'b1;
    return 1'b0;
  endfunction

  function automatic int served_cpus();
    if (cpus_reg == 0) return 1;
    if (cpus_reg > MAX_CPUS) return MAX_CPUS;
    return int'(cpus_reg);
  endfunction

  // advance the scheduler image by one transaction and queue its results
  task automatic schedule_step(input job_row_t r);
    int         pick [MAX_CPUS];
    bit         taken [MAX_JOBS];
    int         ncpu;
    int         best;
    logic [15:0] t;
    logic        done;
    sched_res_t  res;
    t = sched_now;
    if (r.mode == MODE_LOAD) begin
      n_loads++;
      res = '{cpu: 0, vld: 0, idx: 0, fin: 0, t: t, done: 0, rej: 1, last: 1};
      if (jobs_loaded < MAX_JOBS) begin
        job_arr[jobs_loaded] = r.arr;
        job_rem[jobs_loaded] = r.dur;
        job_pri[jobs_loaded] = r.pri;
        res.idx = 6'(jobs_loaded);
        res.rej = 1'b0;
        jobs_loaded++;
      end else begin
        n_rejects++;
      end
      res.done = !any_pending_work();
      if (r.typed) begin
        res.idx  = r.t_idx;
        res.done = r.t_done;
        res.rej  = r.t_rej;
      end
      pending_res.push_back(res);
      return;
    end
    n_ticks++;
    ncpu = served_cpus();
    foreach (taken[i]) taken[i] = 1'b0;
    for (int c = 0; c < ncpu; c++) begin
      best = -1;
      for (int i = 0; i < jobs_loaded; i++) begin
        if (taken[i] || job_rem[i] == 0 || job_arr[i] > t) continue;
        if (best < 0 || job_pri[i] > job_pri[best] ||
            (job_pri[i] == job_pri[best] && job_arr[i] < job_arr[best]))
          best = i;
      end
      pick[c] = best;
      if (best >= 0) taken[best] = 1'b1;
    end
    for (int c = 0; c < ncpu; c++)
      if (pick[c] >= 0) job_rem[pick[c]]--;
    done = !any_pending_work();
    for (int c = 0; c < ncpu; c++) begin
      res = '{cpu: 2'(c), vld: 0, idx: 0, fin: 0, t: t, done: done, rej: 0,
              last: (c == ncpu - 1)};
      if (pick[c] >= 0 && !r.typed) begin
        res.vld = 1'b1;
        res.idx = 6'(pick[c]);
        res.fin = (job_rem[pick[c]] == 0);
      end
      if (r.typed) res.done = r.t_done;
      pending_res.push_back(res);
    end
    if (!done && sched_now != TIME_MAX) sched_now++;
  endtask

  // offer one job transaction, in bursts with random gaps
  task automatic send_item(input job_row_t r);
    int gap;
    if (burst_left == 0) begin
      gap = (int'($urandom_range(0, 99)) < gap_pct) ? int'($urandom_range(1, 6)) : 0;
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r.pri, r.dur, r.arr};
    s_axis_tuser  <= r.mode;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    schedule_step(r);
  endtask

  function automatic job_row_t mk_row(logic mode, logic [15:0] arr, logic [15:0] dur,
                                      logic [7:0] pri, bit typed, logic [5:0] t_idx,
                                      logic t_done, logic t_rej);
    job_row_t r;
    r = '{mode, arr, dur, pri, typed, t_idx, t_done, t_rej};
    return r;
  endfunction

  // drain outstanding results, then write the cpu count while idle
  task automatic write_cpus(input logic [2:0] v);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= {5'd0, v};
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    cpus_reg = v;
  endtask

  function automatic job_row_t rand_load();
    job_row_t r;
    int a;
    a = int'(sched_now) + int'($urandom_range(0, 8));
    if ($urandom_range(0, 3) == 0) a = int'(sched_now) - int'($urandom_range(0, 20));
    if (a < 0) a = 0;
    r = mk_row(MODE_LOAD, 16'(a), 16'($urandom_range(1, 6)),
               ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 3)) : 8'($urandom),
               0, 0, 0, 0);
    if ($urandom_range(0, 11) == 0) r.dur = 16'd0;
    return r;
  endfunction

  // stimulus
  initial begin
    job_row_t    dir_rows[$];
    job_row_t    r;
    logic [2:0]  cpu_plan [8];
    int          loads_left;
    int          ticks_left;

    cpu_plan = '{3'd2, 3'd1, 3'd0, 3'd3, 3'd7, 3'd5, 3'd6, 3'd4};
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    errors = 0; n_loads = 0; n_ticks = 0; n_rejects = 0; n_checked = 0;
    jobs_loaded = 0; sched_now = '0; cpus_reg = 3'(MAX_CPUS);
    stall_pct = 30; gap_pct = 30; hold_req = 1'b0; burst_left = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table: empty tick, ties, zero length, late arrivals
    dir_rows.push_back(mk_row(MODE_TICK, 0, 0, 0, 1, 0, 1, 0));
    dir_rows.push_back(mk_row(MODE_LOAD, 0, 2, 5, 1, 0, 0, 0));
    dir_rows.push_back(mk_row(MODE_LOAD, 0, 0, 255, 1, 1, 0, 0));
    dir_rows.push_back(mk_row(MODE_LOAD, 0, 1, 5, 1, 2, 0, 0));
    dir_rows.push_back(mk_row(MODE_LOAD, 1, 3, 5, 1, 3, 0, 0));
    dir_rows.push_back(mk_row(MODE_LOAD, 0, 1, 0, 1, 4, 0, 0));
    dir_rows.push_back(mk_row(MODE_LOAD, 2, 2, 200, 1, 5, 0, 0));
    dir_rows.push_back(mk_row(MODE_LOAD, 3, 2, 200, 1, 6, 0, 0));
    dir_rows.push_back(mk_row(MODE_LOAD, 1, 4, 5, 1, 7, 0, 0));
    repeat (12) dir_rows.push_back(mk_row(MODE_TICK, 0, 0, 0, 0, 0, 0, 0));
    foreach (dir_rows[i]) send_item(dir_rows[i]);

    // random phases, one cpu count each
    for (int ph = 0; ph < 8; ph++) begin
      write_cpus(cpu_plan[ph]);
      stall_pct = (ph % 3 == 0) ? 0 : int'($urandom_range(10, 70));
      gap_pct   = (ph % 4 == 1) ? 0 : int'($urandom_range(10, 60));
      if (ph == 3) hold_req = 1'b1;
      loads_left = 6;
      ticks_left = 40;
      while (loads_left + ticks_left > 0) begin
        if (loads_left > 0 && ($urandom_range(0, 2) == 0 || ticks_left == 0)) begin
          r = rand_load();
          loads_left--;
        end else begin
          r = mk_row(MODE_TICK, 16'($urandom), 16'($urandom), 8'($urandom), 0, 0, 0, 0);
          ticks_left--;
        end
        send_item(r);
      end
    end

    // extreme jobs, then loads on a full table
    write_cpus(3'd4);
    send_item(mk_row(MODE_LOAD, 16'hFFFF, 16'hFFFF, 8'hFF, 0, 0, 0, 0));
    send_item(mk_row(MODE_LOAD, 16'h0000, 16'hFFFF, 8'h00, 0, 0, 0, 0));
    while (jobs_loaded < MAX_JOBS) send_item(rand_load());
    repeat (6) send_item(mk_row(MODE_LOAD, 16'($urandom), 16'($urandom),
                                8'($urandom), 0, 0, 0, 0));
    repeat (20) send_item(mk_row(MODE_TICK, 0, 0, 0, 0, 0, 0, 0));
    s_axis_tvalid <= 1'b0;

    @(posedge clk_i);
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    $display("covered %0d loads (%0d rejected on a full table) and %0d ticks",
             n_loads, n_rejects, n_ticks);
    $display("%0d result transactions checked, cpu counts 0 to 7 written", n_checked);
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // receiver: random stalls plus one long hold-off
  initial begin
    int  hold_cnt;
    bit  hold_used;
    hold_cnt = 0;
    hold_used = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_used) begin
        hold_used = 1'b1;
        hold_cnt  = LONG_HOLD;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= (int'($urandom_range(0, 99)) >= stall_pct);
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    sched_res_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_res.size() == 0) begin
        $error("result transaction with nothing expected: tdata %h", m_axis_tdata);
        errors++;
      end else begin
        e = pending_res.pop_front();
        n_checked++;
        if (m_axis_tdata[1:0] !== e.cpu) begin
          $error("cpu_index: expected %0d, got %0d", e.cpu, m_axis_tdata[1:0]); errors++;
        end
        if (m_axis_tdata[2] !== e.vld) begin
          $error("job_valid: expected %0d, got %0d", e.vld, m_axis_tdata[2]); errors++;
        end
        if (m_axis_tdata[8:3] !== e.idx) begin
          $error("job_index: expected %0d, got %0d", e.idx, m_axis_tdata[8:3]); errors++;
        end
        if (m_axis_tdata[9] !== e.fin) begin
          $error("job_finished: expected %0d, got %0d", e.fin, m_axis_tdata[9]); errors++;
        end
        if (m_axis_tdata[25:10] !== e.t) begin
          $error("tick_time: expected %0d, got %0d", e.t, m_axis_tdata[25:10]); errors++;
        end
        if (m_axis_tdata[26] !== e.done) begin
          $error("all_done: expected %0d, got %0d", e.done, m_axis_tdata[26]); errors++;
        end
        if (m_axis_tdata[27] !== e.rej) begin
          $error("load_rejected: expected %0d, got %0d", e.rej, m_axis_tdata[27]); errors++;
        end
        if (m_axis_tlast !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, m_axis_tlast); errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

endmodule
